FILE: src/lnss_pkg.sv
// Shared types, constants and the frame row table of the LIN node scan sequencer.
// Depends on nothing; every other file of the block imports it.
package lnss_pkg;

	localparam int IdW      = 6;
	localparam int CountW   = 4;
	localparam int RowW     = 4;
	localparam int PayloadW = 64;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 6;

	// Input tdata: frame_ok, response_byte1 (9 bits, padded to 16).
	localparam int InDataW  = 16;
	// Output tdata: frame_id, payload (70 bits, padded to 72).
	localparam int OutDataW = 72;
	localparam int OutUserW = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_NODES_NEEDED  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_REQUEST_ID    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_RESPONSE_ID   = 2'd2;

	localparam logic [CountW-1:0] NODES_NEEDED_RST  = 4'd2;
	localparam logic [IdW-1:0]    REQUEST_ID_RST    = 6'd60;
	localparam logic [IdW-1:0]    RESPONSE_ID_RST   = 6'd61;

	// Row numbers of the frame table.
	localparam logic [RowW-1:0] ROW_HEAD0      = 4'd0;
	localparam logic [RowW-1:0] ROW_HEAD1      = 4'd1;
	localparam logic [RowW-1:0] ROW_SLOT_FIRST = 4'd2;
	localparam logic [RowW-1:0] ROW_SLOT_LAST  = 4'd8;
	localparam logic [RowW-1:0] ROW_CLOSE0     = 4'd9;
	localparam logic [RowW-1:0] ROW_CLOSE1     = 4'd10;

	localparam logic [CountW-1:0] SLOT_LAST      = 4'd8;
	localparam logic [7:0]        BROADCAST_SLOT = 8'hd0;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_OPEN  = 3'd1,
		PH_HEAD  = 3'd2,
		PH_SLOT  = 3'd3,
		PH_CLOSE = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	typedef struct packed {
		logic       action;
		logic       frame_ok;
		logic [7:0] response_byte1;
	} in_item_t;

	typedef struct packed {
		logic [IdW-1:0]      frame_id;
		logic                transmit;
		logic [PayloadW-1:0] payload;
		logic                scan_done;
	} result_t;

	// Default eight bytes of each transmit row, byte 0 in the low bits.
	function automatic logic [PayloadW-1:0] row_payload(input logic [RowW-1:0] row);
		logic [PayloadW-1:0] bytes;
		case (row)
			4'd0:    bytes = 64'hffffffffffff07ff;
			4'd1:    bytes = 64'hffffffffff0701ff;
			4'd2:    bytes = 64'hffffffff00070200;
			4'd3:    bytes = 64'hffffffff00090600;
			4'd4:    bytes = 64'hffffffff000c0600;
			4'd5:    bytes = 64'hffffffff000d0600;
			4'd6:    bytes = 64'hffffffff000a0600;
			4'd7:    bytes = 64'hffffffff000b0600;
			4'd8:    bytes = 64'hffffffff00000400;
			4'd9:    bytes = 64'hffffffffff0701d0;
			default: bytes = 64'hffffffffff0702d0;
		endcase
		return bytes;
	endfunction

endpackage

FILE: src/lin_node_scan_sequencer_unit.sv
// LIN node scan sequencer, top level: input register, sequencer, result register.
// Depends on lnss_pkg, lnss_in_stage, lnss_seq and lnss_out_stage.
//
// The block drives the master side of a LIN start-up node scan. Each transaction on the
// slave stream is one event: tuser is the action (0 starts the scan, 1 reports that the
// previous frame finished), tdata carries frame_ok and byte 1 of the finished response.
// Each event yields zero or one transaction on the master stream naming the next frame:
// its identifier and payload in tdata, the transmit and scan_done flags in tuser.
// The configuration port writes nodes_needed, request_frame_id and response_frame_id
// by index; the user must write it while the block is idle; the block does not check this.
//
// An event is captured in the input register and processed by the sequencer while it
// is held there; its result is written to the result register when the event moves
// on, which raises m_tvalid. One event is accepted every cycle while the receiver does
// not stall; the single state update of the sequencer sets that figure.
// When the receiver stalls, the result register holds its transaction and the input
// register keeps one more event, after which s_tready drops until the result is taken.
// Reset clears both stages and returns the sequencer to idle with the register defaults.
module lin_node_scan_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lnss_pkg::InDataW-1:0]      s_tdata,  // frame_ok, response_byte1
	input  logic                              s_tuser,  // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lnss_pkg::OutDataW-1:0]     m_tdata,  // frame_id, payload
	output logic [lnss_pkg::OutUserW-1:0]     m_tuser,  // transmit, scan_done
	input  logic                              cfg_we,
	input  logic [lnss_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [lnss_pkg::CfgDataW-1:0]     cfg_data
);
	import lnss_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     out_free;
	logic     step;
	logic     res_valid;
	result_t  res;

	// An event moves on when the result register can take whatever it produces.
	assign step = valid_s1 && out_free;

	lnss_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lnss_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	lnss_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: src/lnss_in_stage.sv
// Input register of the LIN node scan sequencer: unpacks the slave stream into one item.
// Depends on lnss_pkg.
module lnss_in_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [lnss_pkg::InDataW-1:0] s_tdata, // frame_ok, response_byte1
	input  logic                     s_tuser,      // action
	input  logic                     take,
	output logic                     valid_s1,
	output lnss_pkg::in_item_t       item_s1
);
	import lnss_pkg::*;

	logic valid_q;
	in_item_t item_q;

	// The stage is free when empty or when its item moves on this cycle.
	assign s_tready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q.action         <= s_tuser;
			item_q.frame_ok       <= s_tdata[0];
			item_q.response_byte1 <= s_tdata[8:1];
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

FILE: src/lnss_seq.sv
// Scan sequencer state and next-frame logic of the LIN node scan sequencer.
// Holds the configuration registers; depends on lnss_pkg.
module lnss_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lnss_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lnss_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           step,
	input  lnss_pkg::in_item_t             item,
	output logic                           res_valid,
	output lnss_pkg::result_t              res
);
	import lnss_pkg::*;

	logic [CountW-1:0] nodes_needed_q;
	logic [IdW-1:0]    request_id_q;
	logic [IdW-1:0]    response_id_q;

	phase_t            phase_q, phase_d;
	logic              await_q, await_d;
	logic [CountW-1:0] slot_q, slot_d;
	logic [RowW-1:0]   row_q, row_d;
	logic [CountW-1:0] nodes_q, nodes_d;

	logic              emit_tx;
	logic              emit_rx;
	logic              emit_done;
	logic              do_next;
	logic              do_end;
	logic [RowW-1:0]   row_sel;
	logic [PayloadW-1:0] bytes;
	logic [CountW-1:0] slot_prev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_needed_q <= NODES_NEEDED_RST;
			request_id_q   <= REQUEST_ID_RST;
			response_id_q  <= RESPONSE_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NODES_NEEDED: nodes_needed_q <= cfg_data[CountW-1:0];
				CFG_REQUEST_ID:   request_id_q   <= cfg_data[IdW-1:0];
				CFG_RESPONSE_ID:  response_id_q  <= cfg_data[IdW-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			await_q <= 1'b0;
			slot_q  <= '0;
			row_q   <= ROW_SLOT_FIRST;
			nodes_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			await_q <= await_d;
			slot_q  <= slot_d;
			row_q   <= row_d;
			nodes_q <= nodes_d;
		end
	end

	// Next state for one frame event.
	always_comb begin
		phase_d   = phase_q;
		await_d   = await_q;
		slot_d    = slot_q;
		row_d     = row_q;
		nodes_d   = nodes_q;
		emit_tx   = 1'b0;
		emit_rx   = 1'b0;
		emit_done = 1'b0;
		do_next   = 1'b0;
		do_end    = 1'b0;
		if (!item.action) begin
			// A start request restarts the whole sequence.
			phase_d = PH_OPEN;
			row_d   = ROW_HEAD0;
			slot_d  = '0;
			nodes_d = '0;
			emit_tx = 1'b1;
		end else if (phase_q inside {PH_OPEN, PH_HEAD, PH_SLOT, PH_CLOSE}) begin
			if (!await_q) begin
				await_d = 1'b1;
				emit_rx = 1'b1;
			end else begin
				case (phase_q)
					PH_OPEN: begin
						phase_d = PH_HEAD;
						row_d   = ROW_HEAD0;
						emit_tx = 1'b1;
					end
					PH_HEAD: begin
						if (row_q == ROW_HEAD0) begin
							row_d = ROW_HEAD1;
						end else begin
							phase_d = PH_SLOT;
							slot_d  = '0;
							nodes_d = '0;
							row_d   = ROW_SLOT_FIRST;
						end
						emit_tx = 1'b1;
					end
					PH_SLOT: begin
						if (!item.frame_ok) begin
							// A failed slot start skips the slot; a later failure ends the pass.
							if (row_q == ROW_SLOT_FIRST) begin
								do_next = 1'b1;
							end else begin
								do_end = 1'b1;
							end
						end else if (row_q < ROW_SLOT_LAST) begin
							row_d   = row_q + 1'b1;
							emit_tx = 1'b1;
						end else begin
							if (item.response_byte1 == {4'b0, nodes_q}) begin
								nodes_d = nodes_q + 1'b1;
							end
							do_next = 1'b1;
						end
					end
					default: begin
						if (row_q == ROW_CLOSE0) begin
							row_d   = ROW_CLOSE1;
							emit_tx = 1'b1;
						end else begin
							phase_d   = PH_DONE;
							await_d   = 1'b0;
							emit_done = 1'b1;
						end
					end
				endcase
				if (do_next) begin
					slot_d = slot_q + 1'b1;
					if (slot_d > SLOT_LAST) begin
						do_end = 1'b1;
					end else begin
						row_d   = ROW_SLOT_FIRST;
						emit_tx = 1'b1;
					end
				end
				if (do_end) begin
					// The pass count must match exactly, also after an aborted pass.
					if (nodes_d == nodes_needed_q) begin
						phase_d = PH_CLOSE;
						row_d   = ROW_CLOSE0;
					end else begin
						phase_d = PH_HEAD;
						row_d   = ROW_HEAD0;
					end
					emit_tx = 1'b1;
				end
			end
		end
		if (emit_tx) begin
			await_d = 1'b0;
		end
	end

	// Transmit payload from the new row, with slot and count patched in during a pass.
	always_comb begin
		row_sel   = (row_d > ROW_CLOSE1) ? ROW_CLOSE1 : row_d;
		bytes     = row_payload(row_sel);
		slot_prev = slot_d - 1'b1;
		if (phase_d == PH_SLOT) begin
			bytes[7:0] = (slot_d == '0) ? BROADCAST_SLOT : {4'b0, slot_prev};
			if (row_sel == ROW_SLOT_LAST) begin
				bytes[23:16] = {4'b0, nodes_d};
			end
		end
	end

	always_comb begin
		res_valid     = emit_tx || emit_rx || emit_done;
		res.frame_id  = '0;
		res.transmit  = 1'b0;
		res.payload   = '0;
		res.scan_done = emit_done;
		if (emit_tx) begin
			res.frame_id = request_id_q;
			res.transmit = 1'b1;
			res.payload  = bytes;
		end else if (emit_rx) begin
			res.frame_id = response_id_q;
		end
	end

	// After the last slot of a pass the position stays one past it until the next pass.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SLOT |-> slot_q <= SLOT_LAST)
		else $error("slot position beyond the last slot");

	a_slot_rows: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SLOT |-> (row_q >= ROW_SLOT_FIRST && row_q <= ROW_SLOT_LAST))
		else $error("probe row outside the slot rows during a pass");

	a_close_rows: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSE |-> (row_q == ROW_CLOSE0 || row_q == ROW_CLOSE1))
		else $error("probe row outside the closing rows");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.action && (phase_q == PH_DONE || phase_q == PH_IDLE)) |-> !res_valid)
		else $error("frame end while idle or done produced a result");

	a_nodes_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= 4'd9)
		else $error("node count exceeds the number of slots");

endmodule

FILE: src/lnss_out_stage.sv
// Result register of the LIN node scan sequencer: holds one result for the master stream.
// Depends on lnss_pkg.
module lnss_out_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  lnss_pkg::result_t                 res,
	output logic                              free,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lnss_pkg::OutDataW-1:0]     m_tdata, // frame_id, payload
	output logic [lnss_pkg::OutUserW-1:0]     m_tuser  // transmit, scan_done
);
	import lnss_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Free when empty or when the held result is taken this cycle.
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b0, res_q.payload, res_q.frame_id};
	assign m_tuser  = {res_q.scan_done, res_q.transmit};

endmodule
